/* rtl/u8dec_pkg.sv */
package u8dec_pkg;

	// Register indexes of the configuration port.
	typedef enum logic [1:0] {
		REG_DECODE_ENABLE      = 2'd0,
		REG_CONTROLS_UNFLAGGED = 2'd1,
		REG_EIGHT_BIT_OUTPUT   = 2'd2
	} reg_index_t;

	localparam logic [15:0] REPLACEMENT_CP = 16'hFFFD;
	localparam logic [15:0] OVERFLOW_LIMIT = 16'h03FF;
	localparam logic [15:0] SEVEN_BIT_MASK = 16'h007F;
	localparam logic [7:0]  CONT_MASK      = 8'h3F;

	// Depth of the result queue and the width of its fill count.
	localparam int unsigned QUEUE_DEPTH = 3;
	localparam int unsigned QCOUNT_W    = 2;

	typedef struct packed {
		logic decode_enable;
		logic controls_unflagged;
		logic eight_bit_output;
	} cfg_t;

	typedef struct packed {
		logic [15:0] code_point;
		logic        multibyte_flag;
		logic        last;
	} res_t;

	// Results that one byte produces, in delivery order.
	typedef struct packed {
		logic [1:0] count;
		res_t       r0;
		res_t       r1;
	} dec_out_t;

endpackage

/* rtl/u8dec_decode.sv */
module u8dec_decode (
	input  logic              clk,
	input  logic              arst_n,
	input  u8dec_pkg::cfg_t   cfg,
	input  logic              accept,
	input  logic [7:0]        in_byte,
	output u8dec_pkg::dec_out_t dec
);
	import u8dec_pkg::*;

	logic [2:0]  pending_q;
	logic [15:0] acc_q;
	logic [2:0]  pending_d;
	logic [15:0] acc_d;
	logic        pre_v;
	logic        main_v;
	logic [15:0] main_cp;
	logic        main_flag;
	logic [15:0] cp0;
	logic [15:0] cp1;
	logic        flag0;
	logic        flag1;

	// Decide what the byte emits and how the sequence state moves on.
	always_comb begin
		pending_d = pending_q;
		acc_d     = acc_q;
		pre_v     = 1'b0;
		main_v    = 1'b0;
		main_cp   = REPLACEMENT_CP;
		main_flag = 1'b0;
		if (!cfg.decode_enable) begin
			main_v  = 1'b1;
			main_cp = {8'h00, in_byte};
		end else begin
			case (in_byte) inside
				[8'h00:8'h7F]: begin
					pre_v     = (pending_q != 3'd0);
					main_v    = 1'b1;
					main_cp   = {8'h00, in_byte};
					pending_d = 3'd0;
				end
				[8'h80:8'hBF]: begin
					if (pending_q == 3'd0) begin
						main_v = 1'b1;
					end else begin
						if (acc_q > OVERFLOW_LIMIT) begin
							acc_d = REPLACEMENT_CP;
						end else begin
							acc_d = {acc_q[9:0], in_byte[5:0] & CONT_MASK[5:0]};
						end
						pending_d = pending_q - 3'd1;
						if (pending_d == 3'd0) begin
							main_v    = 1'b1;
							main_cp   = acc_d;
							main_flag = !cfg.controls_unflagged;
						end
					end
				end
				[8'hC0:8'hDF]: begin
					pre_v     = (pending_q != 3'd0);
					pending_d = 3'd1;
					acc_d     = {11'd0, in_byte[4:0]};
				end
				[8'hE0:8'hEF]: begin
					pre_v     = (pending_q != 3'd0);
					pending_d = 3'd2;
					acc_d     = {12'd0, in_byte[3:0]};
				end
				[8'hF0:8'hF7]: begin
					pre_v     = (pending_q != 3'd0);
					pending_d = 3'd3;
					acc_d     = {13'd0, in_byte[2:0]};
				end
				[8'hF8:8'hFB]: begin
					pre_v     = (pending_q != 3'd0);
					pending_d = 3'd4;
					acc_d     = {14'd0, in_byte[1:0]};
				end
				[8'hFC:8'hFD]: begin
					pre_v     = (pending_q != 3'd0);
					pending_d = 3'd5;
					acc_d     = {15'd0, in_byte[0]};
				end
				default: begin
					// Bytes 0xFE and 0xFF keep the accumulator.
					pre_v     = (pending_q != 3'd0);
					main_v    = 1'b1;
					pending_d = 3'd0;
				end
			endcase
		end
	end

	// Order the results, replacement first, and with eight-bit output off apply the seven-bit mask.
	always_comb begin
		cp0   = pre_v ? REPLACEMENT_CP : main_cp;
		flag0 = pre_v ? 1'b0 : main_flag;
		cp1   = main_cp;
		flag1 = main_flag;
		if (!cfg.eight_bit_output) begin
			cp0   = cp0 & SEVEN_BIT_MASK;
			cp1   = cp1 & SEVEN_BIT_MASK;
			flag0 = 1'b0;
			flag1 = 1'b0;
		end
		dec.count             = {1'b0, pre_v} + {1'b0, main_v};
		dec.r0.code_point     = cp0;
		dec.r0.multibyte_flag = flag0;
		dec.r0.last           = (dec.count == 2'd1);
		dec.r1.code_point     = cp1;
		dec.r1.multibyte_flag = flag1;
		dec.r1.last           = 1'b1;
	end

	// Sequence state advances only on an accepted byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 3'd0;
			acc_q     <= 16'd0;
		end else if (accept) begin
			pending_q <= pending_d;
			acc_q     <= acc_d;
		end
	end

endmodule

/* rtl/u8dec_queue.sv */
module u8dec_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  u8dec_pkg::dec_out_t dec,
	output logic                space2,
	output logic                out_valid,
	input  logic                out_ready,
	output u8dec_pkg::res_t     head
);
	import u8dec_pkg::*;

	res_t                entry_q [QUEUE_DEPTH];
	res_t                entry_d [QUEUE_DEPTH];
	logic [QCOUNT_W-1:0] count_q;
	logic [QCOUNT_W-1:0] base;
	logic [1:0]          n_push;
	logic                pop;

	assign out_valid = (count_q != '0);
	assign pop       = out_valid && out_ready;
	assign head      = entry_q[0];
	assign base      = count_q - QCOUNT_W'(pop);
	// Room for two results once this cycle's popped result leaves.
	assign space2    = (base <= QCOUNT_W'(QUEUE_DEPTH - 2));
	assign n_push    = push ? dec.count : 2'd0;

	// Shift toward the head on a pop, then append the new results.
	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if (pop && (i < QUEUE_DEPTH - 1)) begin
				entry_d[i] = entry_q[i + 1];
			end else begin
				entry_d[i] = entry_q[i];
			end
			if ((n_push != 2'd0) && (QCOUNT_W'(i) == base)) begin
				entry_d[i] = dec.r0;
			end
			if ((n_push == 2'd2) && (QCOUNT_W'(i) == QCOUNT_W'(base + 1'b1))) begin
				entry_d[i] = dec.r1;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			entry_q[i] <= entry_d[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= base + QCOUNT_W'(n_push);
		end
	end

endmodule

/* rtl/utf8_byte_stream_decoder_unit.sv */
// UTF-8 byte stream decoder. One byte is taken per request on the input channel and
// decoded into 16-bit code points, with U+FFFD for broken sequences; with decoding off,
// bytes pass through. A byte is accepted in every cycle in which in_ready is high: its
// results are worked out in the same cycle from the sequence state and enter a
// three-entry result queue, which hands out one result per cycle while out_ready is
// high. in_ready is high whenever that queue will have room for two results once this
// cycle's popped result leaves, so a byte waits only while two or more results would
// remain queued. Configuration writes land on the next clock edge.
module utf8_byte_stream_decoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [0:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] code_point,
	output logic        multibyte_flag,
	output logic        last
);
	import u8dec_pkg::*;

	cfg_t     cfg_q;
	dec_out_t dec;
	res_t     head;
	logic     accept;

	// Configuration registers; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.decode_enable      <= 1'b0;
			cfg_q.controls_unflagged <= 1'b0;
			cfg_q.eight_bit_output   <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DECODE_ENABLE:      cfg_q.decode_enable      <= cfg_data[0];
				REG_CONTROLS_UNFLAGGED: cfg_q.controls_unflagged <= cfg_data[0];
				REG_EIGHT_BIT_OUTPUT:   cfg_q.eight_bit_output   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign accept = in_valid && in_ready;

	u8dec_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.accept  (accept),
		.in_byte (in_byte),
		.dec     (dec)
	);

	u8dec_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.dec       (dec),
		.space2    (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign code_point     = head.code_point;
	assign multibyte_flag = head.multibyte_flag;
	assign last           = head.last;

endmodule

/* rtl/u8dec_checker.sv */
module u8dec_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] code_point,
	input logic        multibyte_flag,
	input logic        last
);

	// A stalled result holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(code_point)
			&& $stable(multibyte_flag) && $stable(last))
		else $error("stalled result changed");

	// Input back-pressure appears only while results are queued.
	a_ready_needs_backlog: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with an empty result queue");

	// A result that is not the last of its byte is always a replacement.
	a_first_is_replacement: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> !multibyte_flag
			&& (code_point == 16'hFFFD || code_point == 16'h007D))
		else $error("leading result is not a replacement");

	// A completed multibyte character always ends its byte's results.
	a_flag_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && multibyte_flag |-> last)
		else $error("flagged result is not the last one");

endmodule

bind utf8_byte_stream_decoder_unit u8dec_checker u_checker (.*);

/* tb/tb_utf8_byte_stream_decoder_unit.sv */
module tb_utf8_byte_stream_decoder_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import u8dec_pkg::*;

	// Scoreboard: tracks the decoder's sequence state and configuration, and holds the
	// results that accepted bytes are due to produce, oldest first.
	class utf8_scoreboard;
		logic        decode_en;
		logic        unflagged;
		logic        eight_bit;
		logic [2:0]  cont_left;
		logic [15:0] gathered;
		res_t        due_cp_q[$];
		int          errors;

		function new();
			decode_en = 1'b0;
			unflagged = 1'b0;
			eight_bit = 1'b1;
			cont_left = '0;
			gathered  = '0;
			errors    = 0;
		endfunction

		function void set_reg(reg_index_t idx, logic v);
			case (idx)
				REG_DECODE_ENABLE:      decode_en = v;
				REG_CONTROLS_UNFLAGGED: unflagged = v;
				REG_EIGHT_BIT_OUTPUT:   eight_bit = v;
				default: ;
			endcase
		endfunction

		// With eight-bit output off, the code point keeps 7 bits and the flag drops.
		function res_t shape(logic [15:0] cp, logic flag);
			res_t r;
			r.code_point     = eight_bit ? cp : (cp & SEVEN_BIT_MASK);
			r.multibyte_flag = eight_bit & flag;
			r.last           = 1'b0;
			return r;
		endfunction

		// Works out the results of one accepted byte and queues them.
		function void decode_byte(logic [7:0] b);
			res_t out_q[$];
			if (!decode_en) begin
				out_q.push_back(shape({8'h00, b}, 1'b0));
			end else if (b < 8'h80) begin
				// ASCII cuts off any sequence in progress.
				if (cont_left != 0)
					out_q.push_back(shape(REPLACEMENT_CP, 1'b0));
				out_q.push_back(shape({8'h00, b}, 1'b0));
				cont_left = '0;
			end else if (b < 8'hC0) begin
				// Continuation byte: stray, or one more six bits of the character.
				if (cont_left == 0) begin
					out_q.push_back(shape(REPLACEMENT_CP, 1'b0));
				end else begin
					if (gathered > OVERFLOW_LIMIT)
						gathered = REPLACEMENT_CP;
					else
						gathered = (gathered << 6) | {8'h00, b & CONT_MASK};
					cont_left = cont_left - 3'd1;
					if (cont_left == 0)
						out_q.push_back(shape(gathered, ~unflagged));
				end
			end else begin
				// Lead byte, or one of the two bytes that never appear in UTF-8.
				if (cont_left != 0)
					out_q.push_back(shape(REPLACEMENT_CP, 1'b0));
				if (b < 8'hE0) begin
					cont_left = 3'd1;
					gathered  = {11'd0, b[4:0]};
				end else if (b < 8'hF0) begin
					cont_left = 3'd2;
					gathered  = {12'd0, b[3:0]};
				end else if (b < 8'hF8) begin
					cont_left = 3'd3;
					gathered  = {13'd0, b[2:0]};
				end else if (b < 8'hFC) begin
					cont_left = 3'd4;
					gathered  = {14'd0, b[1:0]};
				end else if (b < 8'hFE) begin
					cont_left = 3'd5;
					gathered  = {15'd0, b[0]};
				end else begin
					out_q.push_back(shape(REPLACEMENT_CP, 1'b0));
					cont_left = '0;
				end
			end
			if (out_q.size() != 0)
				out_q[out_q.size() - 1].last = 1'b1;
			foreach (out_q[i])
				due_cp_q.push_back(out_q[i]);
		endfunction

		task report_mismatch(string msg);
			if (errors < 40)
				$display("[%0t] mismatch: %s", $realtime, msg);
			errors++;
		endtask

		// Compares one delivered result with the oldest one due.
		task check_result(logic [15:0] cp, logic flag, logic fin);
			res_t want;
			if (due_cp_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result code_point=%h", cp));
			end else begin
				want = due_cp_q.pop_front();
				if (cp !== want.code_point)
					report_mismatch($sformatf("code_point %h, wanted %h", cp,
						want.code_point));
				if (flag !== want.multibyte_flag)
					report_mismatch($sformatf("multibyte_flag %b, wanted %b for %h",
						flag, want.multibyte_flag, want.code_point));
				if (fin !== want.last)
					report_mismatch($sformatf("last %b, wanted %b for %h", fin,
						want.last, want.code_point));
			end
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [0:0]  cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  in_byte;
	logic        out_valid;
	logic        out_ready;
	logic [15:0] code_point;
	logic        multibyte_flag;
	logic        last;

	utf8_scoreboard sb = new();
	int send_idle_pct;
	int recv_stall_pct;
	int bytes_sent;

	// Bits per phase: {decode_enable, controls_unflagged, eight_bit_output}.
	localparam logic [2:0] PHASE_CFG [8] = '{3'b101, 3'b111, 3'b100, 3'b110,
		3'b001, 3'b010, 3'b101, 3'b111};
	localparam int PHASE_BYTES = 160;

	utf8_byte_stream_decoder_unit u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_byte        (in_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.code_point     (code_point),
		.multibyte_flag (multibyte_flag),
		.last           (last)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// The receiver stalls at random for the current phase's share of cycles.
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Every accepted request updates the prediction; every delivered result is checked.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.decode_byte(in_byte);
			if (out_valid && out_ready)
				sb.check_result(code_point, multibyte_flag, last);
		end
	end

	// Called at a falling edge; returns at the falling edge after the request is taken.
	task send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
		bytes_sent++;
	endtask

	// One write, after which the write enable is low again before the task returns.
	task write_reg(input reg_index_t idx, input logic v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, v);
		@(negedge clk);
	endtask

	// Waits for every due result, then lets a lead byte still in the decoder settle.
	task wait_drained();
		int guard;
		guard = 0;
		while (sb.due_cp_q.size() != 0 && guard < 5000) begin
			@(negedge clk);
			guard++;
		end
		if (sb.due_cp_q.size() != 0) begin
			sb.report_mismatch($sformatf("%0d results never arrived",
				sb.due_cp_q.size()));
			sb.due_cp_q.delete();
		end
		repeat (8) @(negedge clk);
	endtask

	// Mostly well-formed characters of every length with random payload bits, plus
	// cut-off sequences and arbitrary bytes.
	task send_char();
		int kind;
		int n_cont;
		int n_sent;
		logic [7:0] lead;
		logic [5:0] payload;
		kind = $urandom_range(99);
		if (kind < 30) begin
			send_byte(8'($urandom_range(127)));
		end else if (kind < 92) begin
			n_cont = ($urandom_range(99) < 70) ? $urandom_range(1, 2) : $urandom_range(3, 5);
			lead = 8'($urandom);
			case (n_cont)
				1: lead[7:5] = 3'b110;
				2: lead[7:4] = 4'b1110;
				3: lead[7:3] = 5'b11110;
				4: lead[7:2] = 6'b111110;
				default: lead[7:1] = 7'b1111110;
			endcase
			n_sent = (kind < 85) ? n_cont : $urandom_range(0, n_cont - 1);
			send_byte(lead);
			for (int i = 0; i < n_sent; i++) begin
				payload = 6'($urandom);
				send_byte({2'b10, payload});
			end
		end else begin
			send_byte(8'($urandom));
		end
	endtask

	initial begin
		logic [7:0] directed_bytes [$];
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = REG_DECODE_ENABLE;
		cfg_data       = 1'b0;
		in_valid       = 1'b0;
		in_byte        = 8'h00;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		bytes_sent     = 0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Pass-through after reset: bytes come out unchanged.
		directed_bytes = '{8'h00, 8'hFF, 8'h80};
		foreach (directed_bytes[i])
			send_byte(directed_bytes[i]);
		in_valid <= 1'b0;
		wait_drained();

		// Decoding: characters of one to four bytes, a value that overflows, a stray
		// continuation, ASCII and a lead cutting off a sequence, and the two
		// bytes that never occur in UTF-8.
		write_reg(REG_DECODE_ENABLE, 1'b1);
		directed_bytes = '{8'h41, 8'hC3, 8'hA9, 8'hEF, 8'hBF, 8'hBF,
			8'hF0, 8'h9F, 8'h98, 8'h80, 8'h80, 8'hC3, 8'h41, 8'hE2, 8'hC3, 8'hA9,
			8'hFE, 8'hC3, 8'hFF, 8'hFD, 8'h7F};
		foreach (directed_bytes[i])
			send_byte(directed_bytes[i]);
		in_valid <= 1'b0;
		wait_drained();

		// Random phases over the register settings and the idling modes.
		for (int p = 0; p < 8; p++) begin
			write_reg(REG_DECODE_ENABLE, PHASE_CFG[p][2]);
			write_reg(REG_CONTROLS_UNFLAGGED, PHASE_CFG[p][1]);
			write_reg(REG_EIGHT_BIT_OUTPUT, PHASE_CFG[p][0]);
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
				default: begin send_idle_pct = 11; recv_stall_pct = 11; end
			endcase
			bytes_sent = 0;
			while (bytes_sent < PHASE_BYTES)
				send_char();
			in_valid <= 1'b0;
			wait_drained();
		end

		repeat (20) @(negedge clk);
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
